// ===== rtl/core/pixel_mono_gray_bit_matrix_core_macros.svh =====
// Assertion macros for the pixel conversion core.
// Depends on a clock named clk and a reset named rst in the using module.
`ifndef PIXEL_MONO_GRAY_BIT_MATRIX_CORE_MACROS_SVH
`define PIXEL_MONO_GRAY_BIT_MATRIX_CORE_MACROS_SVH

// Check outside reset.
`define PMGBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check at every edge, reset included.
`define PMGBM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/pmgbm_pkg.sv =====
// Types and constants shared by the pixel conversion core.
// No dependencies.
`timescale 1ns / 1ps

package pmgbm_pkg;

  localparam int OP_SLOTS = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] CONV_COLOR = 2'd0;
  localparam logic [1:0] CONV_GRAY  = 2'd1;
  localparam logic [1:0] CONV_EDGE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CONV_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OP_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OP_WORD_A   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OP_WORD_B   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OP_WORD_C   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OP_WORD_D   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_MASKS = 3'd7;

  localparam logic [7:0] EDGE_LEVEL_RST = 8'd128;
  localparam logic [7:0] CHAN_MASK = 8'hFF;

  typedef struct packed {
    logic        left;
    logic [4:0]  shift;
    logic [31:0] mask;
  } op_word_t;

  typedef struct packed {
    logic [31:0] or_mask;
    logic [31:0] and_mask;
  } final_masks_t;

  typedef struct packed {
    logic [1:0]   conv_mode;
    logic [7:0]   edge_level;
    logic [2:0]   op_count;
    op_word_t [OP_SLOTS-1:0] op_words;
    final_masks_t final_masks;
  } cfg_t;

endpackage

// ===== rtl/core/pixel_mono_gray_bit_matrix_core.sv =====
// Pixel conversion core: input register, conversion and bit matrix, output register.
// Depends on pmgbm_pkg, pmgbm_cfg, pmgbm_conv, pmgbm_matrix and the core macros.
//
// Usage:
//   Input channel in_valid/in_stall/pixel_in carries one ARGB pixel per transfer.
//   Output channel out_valid/out_stall/pixel_out carries one converted word per
//   input transfer, in order.
//   An accepted pixel passes through the input register and then the output
//   register before out_valid rises for it. Throughput is one pixel per cycle
//   while out_stall is low; the conversion and bit matrix sit in one
//   combinational stage between the two registers.
//   When out_stall is high the output word holds; the input register still takes
//   a pixel if it is empty, so up to two pixels are held while stalled. in_stall
//   rises only when both registers are full and the output is stalled.
//   Configuration is written through cfg_we/cfg_index/cfg_data, one register per
//   cycle, while no pixel is in flight.
//   Synchronous reset empties both registers and restores the register defaults:
//   color mode, edge level 128, no operations, AND mask all ones, OR mask zero.
`timescale 1ns / 1ps
`include "pixel_mono_gray_bit_matrix_core_macros.svh"

module pixel_mono_gray_bit_matrix_core
  import pmgbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           pixel_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           pixel_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg;
  logic        s1_valid;
  logic [31:0] s1_pixel;
  logic [31:0] converted;
  logic [31:0] result;
  logic        out_open;
  logic        s1_open;

  pmgbm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pmgbm_conv u_conv (
    .conv_mode  (cfg.conv_mode),
    .edge_level (cfg.edge_level),
    .pixel      (s1_pixel),
    .converted  (converted)
  );

  pmgbm_matrix u_matrix (
    .op_count    (cfg.op_count),
    .op_words    (cfg.op_words),
    .final_masks (cfg.final_masks),
    .value       (converted),
    .result      (result)
  );

  assign out_open = !out_valid || !out_stall;
  assign s1_open  = !s1_valid || out_open;
  assign in_stall = !s1_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_open) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_open && in_valid) begin
      s1_pixel <= pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_open) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open && s1_valid) begin
      pixel_out <= result;
    end
  end

  `PMGBM_ASSERT(a_stall_needs_full, in_stall |-> (s1_valid && out_valid && out_stall), "input stalled with room")
  `PMGBM_ASSERT(a_in_to_s1, (in_valid && !in_stall) |=> s1_valid, "accepted pixel lost")
  `PMGBM_ASSERT(a_s1_to_out, (s1_valid && !(out_valid && out_stall)) |=> out_valid, "pixel not advanced")
  `PMGBM_ASSERT(a_held_s1, (s1_valid && out_valid && out_stall) |=> s1_valid, "held pixel dropped")
  `PMGBM_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> (!s1_valid && !out_valid), "not empty after reset")

endmodule

// ===== rtl/core/pmgbm_cfg.sv =====
// Configuration register file for the pixel conversion core.
// Depends on pmgbm_pkg.
`timescale 1ns / 1ps

module pmgbm_cfg
  import pmgbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.conv_mode   <= CONV_COLOR;
      cfg.edge_level  <= EDGE_LEVEL_RST;
      cfg.op_count    <= '0;
      cfg.op_words    <= '0;
      cfg.final_masks <= '{or_mask: 32'h0, and_mask: 32'hFFFF_FFFF};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CONV_MODE:   cfg.conv_mode <= cfg_data[1:0];
        REG_EDGE_LEVEL:  cfg.edge_level <= cfg_data[7:0];
        REG_OP_COUNT:    cfg.op_count <= cfg_data[2:0];
        REG_OP_WORD_A:   cfg.op_words[0] <= cfg_data[$bits(op_word_t)-1:0];
        REG_OP_WORD_B:   cfg.op_words[1] <= cfg_data[$bits(op_word_t)-1:0];
        REG_OP_WORD_C:   cfg.op_words[2] <= cfg_data[$bits(op_word_t)-1:0];
        REG_OP_WORD_D:   cfg.op_words[3] <= cfg_data[$bits(op_word_t)-1:0];
        REG_FINAL_MASKS: cfg.final_masks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/pmgbm_conv.sv =====
// Color, grayscale and edge-threshold conversion of one ARGB pixel.
// Depends on pmgbm_pkg.
`timescale 1ns / 1ps

module pmgbm_conv
  import pmgbm_pkg::*;
(
  input  logic [1:0]  conv_mode,
  input  logic [7:0]  edge_level,
  input  logic [31:0] pixel,
  output logic [31:0] converted
);

  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [12:0] weighted;
  logic [7:0]  gray;

  assign red   = pixel[23:16] & CHAN_MASK;
  assign green = pixel[15:8] & CHAN_MASK;
  assign blue  = pixel[7:0] & CHAN_MASK;

  // 11R + 16G + 5B, at most 8160
  assign weighted = 13'({red, 3'b000}) + 13'({red, 1'b0}) + 13'(red)
                  + 13'({green, 4'b0000})
                  + 13'({blue, 2'b00}) + 13'(blue);
  assign gray = weighted[12:5];

  always_comb begin
    case (conv_mode)
      CONV_GRAY: converted = {pixel[31:24], gray, gray, gray};
      CONV_EDGE: converted = {pixel[31:24], (gray < edge_level) ? 24'h0 : 24'hFF_FFFF};
      default:   converted = pixel;
    endcase
  end

endmodule

// ===== rtl/core/pmgbm_matrix.sv =====
// Mask/shift bit matrix and final AND/OR masks.
// Depends on pmgbm_pkg.
`timescale 1ns / 1ps

module pmgbm_matrix
  import pmgbm_pkg::*;
(
  input  logic [2:0]              op_count,
  input  op_word_t [OP_SLOTS-1:0] op_words,
  input  final_masks_t            final_masks,
  input  logic [31:0]             value,
  output logic [31:0]             result
);

  logic [31:0] acc;
  logic [31:0] sel;

  always_comb begin
    acc = '0;
    sel = '0;
    if (op_count == 3'd0) begin
      acc = value;
    end else begin
      for (int i = 0; i < OP_SLOTS; i++) begin
        sel = value & op_words[i].mask;
        if (op_count > 3'(i)) begin
          acc = acc | (op_words[i].left ? (sel << op_words[i].shift)
                                        : (sel >> op_words[i].shift));
        end
      end
    end
    result = (acc & final_masks.and_mask) | final_masks.or_mask;
  end

endmodule
